// File: rtl/assert_macros.svh
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
package b64d_pkg;

  typedef enum logic [1:0] {
    CLS_SKIP = 2'd0,
    CLS_PAD  = 2'd1,
    CLS_BAD  = 2'd2,
    CLS_DATA = 2'd3
  } char_cls_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_PAD = 2'd1,
    ST_BAD = 2'd2
  } end_status_e;

  typedef struct packed {
    char_cls_e   cls;
    logic [5:0]  sextet;
    logic        last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

endpackage

// File: rtl/b64d_front.sv
`timescale 1ns / 1ps
module b64d_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_byte_i,
  input  logic                 last_char_i,
  input  b64d_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output b64d_pkg::q_entry_t   push_entry_o
);
  import b64d_pkg::*;

  char_cls_e  cls;
  logic [5:0] sextet;

  // Map the character to its class and six-bit value.
  always_comb begin
    cls    = CLS_BAD;
    sextet = '0;
    if (char_byte_i == CharCr || char_byte_i == CharLf) begin
      cls = CLS_SKIP;
    end else if (char_byte_i == CharPad) begin
      cls = CLS_PAD;
    end else if (char_byte_i >= 8'h41 && char_byte_i <= 8'h5A) begin
      cls    = CLS_DATA;
      sextet = 6'(char_byte_i - 8'h41);
    end else if (char_byte_i >= 8'h61 && char_byte_i <= 8'h7A) begin
      cls    = CLS_DATA;
      sextet = 6'(char_byte_i - 8'h61 + 8'd26);
    end else if (char_byte_i >= 8'h30 && char_byte_i <= 8'h39) begin
      cls    = CLS_DATA;
      sextet = 6'(char_byte_i - 8'h30 + 8'd52);
    end else if (char_byte_i == CharPlus) begin
      cls    = CLS_DATA;
      sextet = SextetPlus;
    end else if (char_byte_i == CharSlash) begin
      cls    = CLS_DATA;
      sextet = SextetSlash;
    end
  end

  assign in_ready_o          = !q_status_i.full;
  assign push_o              = in_valid_i && !q_status_i.full;
  assign push_entry_o.cls    = cls;
  assign push_entry_o.sextet = sextet;
  assign push_entry_o.last   = last_char_i;

endmodule

// File: rtl/b64d_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64d_pkg::q_entry_t   push_entry_i,
  input  logic                 pop_i,
  output b64d_pkg::q_entry_t   head_o,
  output b64d_pkg::q_status_t  status_o
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= FullCnt)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && count_q == '0)
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && !pop_i && count_q == FullCnt)

endmodule

// File: rtl/b64d_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64d_pkg::q_entry_t   head_i,
  input  b64d_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 byte_valid_o,
  output logic                 end_of_message_o,
  output logic [1:0]           end_status_o
);
  import b64d_pkg::*;

  logic [5:0]  res_bits_q, res_bits_d;
  logic [2:0]  res_cnt_q, res_cnt_d;
  logic        stopped_q, stopped_d;
  end_status_e cause_q, cause_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  data_q;
  logic        bvalid_q, eom_q;
  end_status_e status_q;

  logic [11:0] acc;
  logic [3:0]  cnt;
  logic [3:0]  rest;
  logic        have_byte;
  logic [7:0]  byte_val;
  logic        has_result;

  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    res_bits_d = res_bits_q;
    res_cnt_d  = res_cnt_q;
    stopped_d  = stopped_q;
    cause_d    = cause_q;
    have_byte  = 1'b0;
    byte_val   = '0;
    acc        = {res_bits_q, head_i.sextet};
    cnt        = {1'b0, res_cnt_q} + 4'd6;
    rest       = cnt - 4'd8;
    if (!stopped_q) begin
      case (head_i.cls)
        CLS_PAD: begin
          stopped_d = 1'b1;
          cause_d   = ST_PAD;
        end
        CLS_BAD: begin
          stopped_d = 1'b1;
          cause_d   = ST_BAD;
        end
        CLS_DATA: begin
          if (cnt >= 4'd8) begin
            have_byte  = 1'b1;
            byte_val   = 8'(acc >> rest);
            res_bits_d = 6'(acc & ((12'd1 << rest) - 12'd1));
            res_cnt_d  = 3'(rest);
          end else begin
            res_bits_d = acc[5:0];
            res_cnt_d  = 3'(cnt);
          end
        end
        default: ;
      endcase
    end
    has_result = have_byte || head_i.last;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = has_result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q  <= '0;
      res_cnt_q   <= '0;
      stopped_q   <= 1'b0;
      cause_q     <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (head_i.last) begin
          // drop leftover bits and rearm for the next message
          res_bits_q <= '0;
          res_cnt_q  <= '0;
          stopped_q  <= 1'b0;
          cause_q    <= ST_OK;
        end else begin
          res_bits_q <= res_bits_d;
          res_cnt_q  <= res_cnt_d;
          stopped_q  <= stopped_d;
          cause_q    <= cause_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_result) begin
      data_q   <= byte_val;
      bvalid_q <= have_byte;
      eom_q    <= head_i.last;
      status_q <= head_i.last ? cause_d : ST_OK;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = data_q;
  assign byte_valid_o     = bvalid_q;
  assign end_of_message_o = eom_q;
  assign end_status_o     = status_q;

  `ASSERT_CLK(a_res_cnt_even, clk_i, rst_ni, !res_cnt_q[0] && res_cnt_q != 3'd7)
  `ASSERT_CLK(a_result_nonempty, clk_i, rst_ni, !out_valid_q || bvalid_q || eom_q)
  `ASSERT_CLK(a_last_rearms, clk_i, rst_ni,
              (pop_o && head_i.last) |=> (res_cnt_q == '0 && !stopped_q))

endmodule

// File: rtl/base64_stream_decoder_top.sv
// Base64 stream decoder: one character word in, at most one result word out.
// Throughput: one character per cycle sustained while out_ready_i stays high.
// Path: the edge that accepts a character pushes it into the queue; the edge that
// pops it from the queue accumulates it into the output register, where its result
// is then valid (the pop waits while a held result has not been taken).
// Reset (rst_ni low, asynchronous): queue empty, bit accumulator cleared, no result.
`timescale 1ns / 1ps
module base64_stream_decoder_top #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_message_o,
  output logic [1:0] end_status_o
);
  import b64d_pkg::*;

  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  // Front: classify each character (skip, pad, invalid, data) and push it.
  b64d_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_byte_i  (char_byte_i),
    .last_char_i  (last_char_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Queue: decouples the input handshake from output backpressure.
  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Back: bit accumulator, stop tracking and registered result word.
  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o),
    .end_status_o     (end_status_o)
  );

endmodule
